// File: design/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// Package for the multi-pattern string matcher
// Shared widths, operation codes, status codes and the beat payload types.
// ----------------------------------------------------------------------------
package mpsm_pkg;

   localparam int unsigned NODES_DEFAULT    = 1024;
   localparam int unsigned ALPHABET_DEFAULT = 26;
   localparam int unsigned COUNT_W          = 16;
   localparam int unsigned TOTAL_W          = 32;

   localparam logic [2:0] OP_INSERT  = 3'd0;
   localparam logic [2:0] OP_END     = 3'd1;
   localparam logic [2:0] OP_BUILD   = 3'd2;
   localparam logic [2:0] OP_SCAN    = 3'd3;
   localparam logic [2:0] OP_RESTART = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOBUILD = 2'd2;

   typedef struct packed {
      logic [2:0] opcode;
      logic [4:0] letter;
   } req_type;

   typedef struct packed {
      logic [15:0] matches_here;
      logic [31:0] total_matches;
      logic [1:0]  status;
   } rsp_type;

endpackage

// File: design/mpsm_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one opcode and letter per beat.
// ----------------------------------------------------------------------------
interface mpsm_req_if;
   logic                  valid;
   logic                  ready;
   mpsm_pkg::req_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/mpsm_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one match result per beat.
// ----------------------------------------------------------------------------
interface mpsm_rsp_if;
   logic                  valid;
   logic                  ready;
   mpsm_pkg::rsp_type     payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/mpsm_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module mpsm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// File: design/multi_pattern_string_matcher.sv
// ----------------------------------------------------------------------------
// Multi-pattern string matcher
// Aho-Corasick trie with failure links, built and scanned by one sequencer.
// ----------------------------------------------------------------------------
// Usage: each request beat carries an opcode and a letter, and every request
// beat yields exactly one response beat, in order. Insert and end beats grow
// the trie, a build beat computes the failure links and suffix match counts
// breadth-first, scan beats step through text and restart clears the scan state.
// All tables sit in single-port RAMs under one sequencer, one access per port
// and cycle. A scan follows failure links until a node has a child on the
// letter or the root is reached. A build handles the root first, then each
// queued node letter by letter, walking the failure chain for each child found,
// and then finishes. The request side is ready only while the sequencer is
// idle, so one item ends before the next begins; the next beat can be taken in
// the same cycle as the response becomes valid. After reset a clearing pass
// sweeps the tables before the first request is taken. A stalled response is
// held in the output register; the next request is still taken, and its result
// waits in the final state until the register is free.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher #(
   parameter int unsigned NODES    = mpsm_pkg::NODES_DEFAULT,
   parameter int unsigned ALPHABET = mpsm_pkg::ALPHABET_DEFAULT
) (
   input logic  clock,
   input logic  reset,
   mpsm_req_if.sink   req,
   mpsm_rsp_if.source rsp
);
   localparam int unsigned NW   = $clog2(NODES);
   localparam int unsigned CD   = NODES * ALPHABET;
   localparam int unsigned CW   = $clog2(CD);
   localparam int unsigned UW   = NW + 1;
   localparam int unsigned CNTW = mpsm_pkg::COUNT_W;
   localparam int unsigned TOTW = mpsm_pkg::TOTAL_W;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_INS_RD, S_INS_WAIT, S_INS_DEC, S_END_RD, S_END_WAIT,
      S_END_WR, S_B_INIT, S_B_POP, S_B_POPW, S_B_CRD, S_B_CWAIT, S_B_KID,
      S_B_WRD, S_B_WWAIT, S_B_WCHK, S_B_FRD, S_B_FWAIT, S_B_DEST, S_B_MRD,
      S_B_MWAIT, S_B_WRITE, S_S_RD, S_S_WAIT, S_S_CHK,
      S_S_FWAIT, S_S_MRD, S_S_MWAIT, S_DONE
   } state_type;

   // RAM ports
   logic          c_we;   logic [CW-1:0] c_a;   logic [NW-1:0] c_wd, c_rd;
   logic          f_we;   logic [NW-1:0] f_a;   logic [NW-1:0] f_wd, f_rd;
   logic          m_we;   logic [NW-1:0] m_a;   logic [CNTW-1:0] m_wd, m_rd;
   logic          e_we;   logic [NW-1:0] e_a;   logic [CNTW-1:0] e_wd, e_rd;
   logic          q_we;   logic [NW-1:0] q_a;   logic [NW-1:0] q_wd, q_rd;

   mpsm_ram #(.WIDTH(NW), .DEPTH(CD)) u_child (
      .clock(clock), .wr_en(c_we), .addr(c_a), .wr_data(c_wd), .rd_data(c_rd));
   mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
      .clock(clock), .wr_en(f_we), .addr(f_a), .wr_data(f_wd), .rd_data(f_rd));
   mpsm_ram #(.WIDTH(CNTW), .DEPTH(NODES)) u_match (
      .clock(clock), .wr_en(m_we), .addr(m_a), .wr_data(m_wd), .rd_data(m_rd));
   mpsm_ram #(.WIDTH(CNTW), .DEPTH(NODES)) u_ends (
      .clock(clock), .wr_en(e_we), .addr(e_a), .wr_data(e_wd), .rd_data(e_rd));
   mpsm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_queue (
      .clock(clock), .wr_en(q_we), .addr(q_a), .wr_data(q_wd), .rd_data(q_rd));

   state_type     state_ff, state_in;
   logic [CW-1:0] clr_ff, clr_in;
   logic [2:0]    op_ff, op_in;
   logic [4:0]    sym_ff, sym_in;
   logic [UW-1:0] used_ff, used_in;
   logic [NW-1:0] icur_ff, icur_in;
   logic [NW-1:0] scur_ff, scur_in;
   logic [TOTW-1:0] tot_ff, tot_in;
   logic          built_ff, built_in;
   logic [UW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [NW-1:0] node_ff, node_in, kid_ff, kid_in, dest_ff, dest_in;
   logic [7:0]    bs_ff, bs_in;
   logic [UW-1:0] guard_ff, guard_in;
   logic          rv_ff, rv_in;
   mpsm_pkg::rsp_type rp_ff, rp_in;
   mpsm_pkg::rsp_type wk_ff, wk_in;

   // Child address, node*ALPHABET+sym; a multiply by a small constant.
   logic [NW-1:0] ca_node;
   logic [7:0]    ca_sym;
   logic [CW:0]   ca_full;

   logic [CNTW:0] msum;
   assign msum = {1'b0, e_rd} + {1'b0, m_rd};
   logic [TOTW:0] tsum;
   assign tsum = {1'b0, tot_ff} + (TOTW+1)'(m_rd);

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = rv_ff;
   assign rsp.payload = rp_ff;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; op_in = op_ff; sym_in = sym_ff;
      used_in = used_ff; icur_in = icur_ff; scur_in = scur_ff; tot_in = tot_ff;
      built_in = built_ff; head_in = head_ff; tail_in = tail_ff;
      node_in = node_ff; kid_in = kid_ff; dest_in = dest_ff; bs_in = bs_ff;
      guard_in = guard_ff; rp_in = rp_ff; wk_in = wk_ff;
      rv_in = rv_ff && !rsp.ready;
      c_we = 1'b0; f_we = 1'b0; m_we = 1'b0; e_we = 1'b0; q_we = 1'b0;
      ca_node = '0; ca_sym = '0;
      c_a = '0; c_wd = '0;
      f_a = '0; f_wd = '0; m_a = '0; m_wd = '0; e_a = '0; e_wd = '0;
      q_a = '0; q_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            c_we = 1'b1; c_a = clr_ff;
            f_we = 1'b1; m_we = 1'b1; e_we = 1'b1;
            f_a = clr_ff[NW-1:0]; m_a = clr_ff[NW-1:0]; e_a = clr_ff[NW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CW'(CD - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.payload.opcode; sym_in = req.payload.letter;
               wk_in = '{matches_here: '0, total_matches: tot_ff,
                         status: mpsm_pkg::ST_OK};
               priority if (req.payload.opcode == mpsm_pkg::OP_INSERT) begin
                  state_in = (32'(req.payload.letter) < ALPHABET) ? S_INS_RD : S_DONE;
               end else if (req.payload.opcode == mpsm_pkg::OP_END) begin
                  state_in = S_END_RD;
               end else if (req.payload.opcode == mpsm_pkg::OP_BUILD) begin
                  state_in = S_B_INIT;
               end else if (req.payload.opcode == mpsm_pkg::OP_SCAN) begin
                  if (!built_ff) begin
                     wk_in.status = mpsm_pkg::ST_NOBUILD; state_in = S_DONE;
                  end else begin
                     state_in = S_S_RD;
                  end
               end else if (req.payload.opcode == mpsm_pkg::OP_RESTART) begin
                  scur_in = '0; tot_in = '0; wk_in.total_matches = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_INS_RD: begin
            ca_node = icur_ff; ca_sym = 8'(sym_ff); state_in = S_INS_WAIT;
         end
         S_INS_WAIT: begin
            ca_node = icur_ff; ca_sym = 8'(sym_ff); state_in = S_INS_DEC;
         end
         S_INS_DEC: begin
            ca_node = icur_ff; ca_sym = 8'(sym_ff);
            if (c_rd != '0) begin
               icur_in = c_rd;
            end else if (used_ff >= UW'(NODES)) begin
               wk_in.status = mpsm_pkg::ST_FULL;
            end else begin
               c_we = 1'b1; c_wd = used_ff[NW-1:0];
               icur_in = used_ff[NW-1:0]; used_in = used_ff + 1'b1;
               built_in = 1'b0;
            end
            state_in = S_DONE;
         end
         S_END_RD:   begin e_a = icur_ff; state_in = S_END_WAIT; end
         S_END_WAIT: begin e_a = icur_ff; state_in = S_END_WR; end
         S_END_WR: begin
            e_a = icur_ff; e_we = 1'b1;
            e_wd = (e_rd == '1) ? e_rd : e_rd + 1'b1;
            icur_in = '0; built_in = 1'b0; state_in = S_DONE;
         end
         // Root: link 0, count = own ends, enqueue.
         S_B_INIT: begin
            q_we = 1'b1; q_a = '0; q_wd = '0;
            head_in = '0; tail_in = UW'(1);
            kid_in = '0; dest_in = '0; node_in = '0;
            state_in = S_B_MRD;
         end
         S_B_POP: begin
            if (head_ff == tail_ff) begin
               built_in = 1'b1; state_in = S_DONE;
            end else begin
               q_a = head_ff[NW-1:0]; state_in = S_B_POPW;
            end
         end
         S_B_POPW: begin q_a = head_ff[NW-1:0]; state_in = S_B_CRD; end
         S_B_CRD: begin
            node_in = q_rd; head_in = head_ff + 1'b1; bs_in = '0;
            state_in = S_B_CWAIT;
         end
         S_B_CWAIT: begin
            ca_node = node_ff; ca_sym = bs_ff; state_in = S_B_KID;
         end
         S_B_KID: begin
            ca_node = node_ff; ca_sym = bs_ff;
            // The read issued last cycle is now valid.
            if (c_rd == '0) begin
               state_in = S_B_WCHK;
               kid_in = '0;
            end else begin
               kid_in = c_rd; dest_in = '0; guard_in = '0;
               state_in = (node_ff == '0) ? S_B_MRD : S_B_FRD;
            end
         end
         S_B_FRD:   begin f_a = node_ff; state_in = S_B_FWAIT; end
         S_B_FWAIT: begin f_a = node_ff; state_in = S_B_DEST; end
         S_B_DEST: begin dest_in = f_rd; state_in = S_B_WRD; end
         // Walk the failure chain of dest until it has a child on this letter, reaches the root or hits the guard.
         S_B_WRD: begin
            ca_node = dest_ff; ca_sym = bs_ff; state_in = S_B_WWAIT;
         end
         S_B_WWAIT: begin
            ca_node = dest_ff; ca_sym = bs_ff; f_a = dest_ff;
            state_in = S_B_WCHK;
         end
         S_B_WCHK: begin
            if (kid_ff == '0) begin
               bs_in = bs_ff + 1'b1;
               state_in = (32'(bs_ff) + 1 >= ALPHABET) ? S_B_POP : S_B_CWAIT;
            end else if (c_rd != '0 || dest_ff == '0 || guard_ff >= UW'(NODES)) begin
               dest_in = (guard_ff >= UW'(NODES)) ? '0 : c_rd;
               state_in = S_B_MRD;
            end else begin
               f_a = dest_ff;
               dest_in = f_rd; guard_in = guard_ff + 1'b1;
               state_in = S_B_WRD;
            end
         end
         S_B_MRD:   begin m_a = dest_ff; e_a = kid_ff; state_in = S_B_MWAIT; end
         S_B_MWAIT: begin m_a = dest_ff; e_a = kid_ff; state_in = S_B_WRITE; end
         S_B_WRITE: begin
            f_we = 1'b1; f_a = kid_ff; f_wd = dest_ff;
            m_we = 1'b1; m_a = kid_ff;
            // The root's own count takes only its own ends.
            if (kid_ff == '0) m_wd = e_rd;
            else m_wd = msum[CNTW] ? '1 : msum[CNTW-1:0];
            if (kid_ff == '0) begin
               state_in = S_B_POP;
            end else begin
               if (tail_ff < UW'(NODES)) begin
                  q_we = 1'b1; q_a = tail_ff[NW-1:0]; q_wd = kid_ff;
                  tail_in = tail_ff + 1'b1;
               end
               bs_in = bs_ff + 1'b1;
               state_in = (32'(bs_ff) + 1 >= ALPHABET) ? S_B_POP : S_B_CWAIT;
            end
         end
         S_S_RD: begin
            ca_node = scur_ff; ca_sym = 8'(sym_ff); guard_in = '0;
            state_in = S_S_WAIT;
         end
         S_S_WAIT: begin
            ca_node = scur_ff; ca_sym = 8'(sym_ff); f_a = scur_ff;
            state_in = S_S_CHK;
         end
         S_S_CHK: begin
            if (32'(sym_ff) >= ALPHABET) begin
               scur_in = '0; state_in = S_S_MRD;
            end else if (c_rd != '0) begin
               scur_in = c_rd; state_in = S_S_MRD;
            end else if (scur_ff == '0 || guard_ff >= UW'(NODES)) begin
               scur_in = '0; state_in = S_S_MRD;
            end else begin
               f_a = scur_ff; scur_in = f_rd; guard_in = guard_ff + 1'b1;
               state_in = S_S_FWAIT;
            end
         end
         S_S_FWAIT: begin
            ca_node = scur_ff; ca_sym = 8'(sym_ff); state_in = S_S_WAIT;
         end
         S_S_MRD:   begin m_a = scur_ff; state_in = S_S_MWAIT; end
         S_S_MWAIT: begin
            m_a = scur_ff;
            state_in = S_DONE;
         end
         // Hold here until the output register is free.
         S_DONE: begin
            m_a = scur_ff;
            if (!rv_ff || rsp.ready) begin
               rp_in = wk_ff;
               if (op_ff == mpsm_pkg::OP_SCAN && wk_ff.status == mpsm_pkg::ST_OK) begin
                  tot_in = tsum[TOTW] ? '1 : tsum[TOTW-1:0];
                  rp_in.matches_here = m_rd;
                  rp_in.total_matches = tsum[TOTW] ? '1 : tsum[TOTW-1:0];
               end
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ca_full = (CW+1)'(ca_node) * (CW+1)'(ALPHABET) + (CW+1)'(ca_sym);
      if (state_ff != S_CLEAR) c_a = ca_full[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; used_ff <= UW'(1); icur_ff <= '0;
         scur_ff <= '0; tot_ff <= '0; built_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; used_ff <= used_in;
         icur_ff <= icur_in; scur_ff <= scur_in; tot_ff <= tot_in;
         built_ff <= built_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; sym_ff <= sym_in; head_ff <= head_in; tail_ff <= tail_in;
      node_ff <= node_in; kid_ff <= kid_in; dest_ff <= dest_in; bs_ff <= bs_in;
      guard_ff <= guard_in; rp_ff <= rp_in; wk_ff <= wk_in;
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready) else $error("accept while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload)))
      else $error("response dropped");
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      (used_ff >= UW'(1)) && (used_ff <= UW'(NODES))) else $error("node count");
`endif
endmodule
